>>> sv/mbr_pkg.sv
// Shared constants, request codes and the command struct of the MSB-first bit reader.
package mbr_pkg;

  localparam int DEF_BUF_BYTES     = 256;
  localparam int DEF_MAX_READ_BITS = 512;

  localparam int TYPE_W  = 2;
  localparam int IDX_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int BCNT_W  = 10;
  localparam int SKIP_W  = 9;
  localparam int LEN_W   = 9;
  localparam int BVAL_W  = 4;

  localparam logic [TYPE_W-1:0] REQ_LOAD = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_READ = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_SKIP = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Command from the request decoder to the extraction sequencer.
  typedef struct packed {
    logic              go;     // start a read of bits bits
    logic              err;    // emit one error result
    logic [2:0]        shift;  // bit position inside the first byte
    logic [BCNT_W-1:0] bits;
  } mbr_cmd_t;

endpackage

>>> sv/mbr_ifs.sv
// Request and result channel interfaces of the MSB-first bit reader.
interface mbr_req_if import mbr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [IDX_W-1:0]  load_index;
  logic [BYTE_W-1:0] load_byte;
  logic [BCNT_W-1:0] bit_count;
  logic [SKIP_W-1:0] skip_count;

  modport source (output valid, req_type, load_index, load_byte, bit_count, skip_count,
                  input ready);
  modport sink (input valid, req_type, load_index, load_byte, bit_count, skip_count,
                output ready);
endinterface

interface mbr_res_if import mbr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [BVAL_W-1:0] bits_valid;
  logic              last;
  logic              status;

  modport source (output valid, data_byte, bits_valid, last, status, input ready);
  modport sink (input valid, data_byte, bits_valid, last, status, output ready);
endinterface

>>> sv/mbr_ctrl.sv
// Request decoder: length register, bit offset, bounds checks and load writes.
module mbr_ctrl import mbr_pkg::*; #(
  parameter int BUF_BYTES     = DEF_BUF_BYTES,
  parameter int MAX_READ_BITS = DEF_MAX_READ_BITS,
  localparam int AW           = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [TYPE_W-1:0] req_type,
  input  logic [IDX_W-1:0]  load_index,
  input  logic [BYTE_W-1:0] load_byte,
  input  logic [BCNT_W-1:0] bit_count,
  input  logic [SKIP_W-1:0] skip_count,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_data,
  output mbr_cmd_t          cmd,
  output logic [AW-1:0]     base,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [BYTE_W-1:0] wr_data
);

  localparam int OFF_W  = $clog2(8 * BUF_BYTES + 1);
  localparam int SUM_W  = ((OFF_W > BCNT_W) ? OFF_W : BCNT_W) + 1;
  localparam int ICMP_W = AW + IDX_W + 1;
  localparam logic [SUM_W-1:0]  BufLen  = SUM_W'(BUF_BYTES);
  localparam logic [BCNT_W-1:0] MaxBits = BCNT_W'(MAX_READ_BITS);
  localparam logic [ICMP_W-1:0] IdxLim  = ICMP_W'(BUF_BYTES);

  logic [LEN_W-1:0] data_length;
  logic [OFF_W-1:0] offset;

  logic [SUM_W-1:0] eff_len;
  logic [SUM_W-1:0] rd_sum;
  logic [SUM_W-1:0] rd_end;
  logic [SUM_W-1:0] sk_end;
  logic [SUM_W-1:0] sk_sum;
  logic             rd_err;
  logic             sk_err;
  logic             is_read;
  logic             is_skip;

  assign is_read = accept && (req_type == REQ_READ);
  assign is_skip = accept && (req_type == REQ_SKIP);

  assign eff_len = (SUM_W'(data_length) < BufLen) ? SUM_W'(data_length) : BufLen;
  assign rd_sum  = SUM_W'(offset) + SUM_W'(bit_count);
  assign rd_end  = (rd_sum + SUM_W'(7)) >> 3;
  assign rd_err  = (bit_count > MaxBits) || (rd_end > eff_len);
  assign sk_end  = ((SUM_W'(offset) + SUM_W'(7)) >> 3) + SUM_W'(skip_count);
  assign sk_err  = sk_end > eff_len;
  // only taken when the skip passed, so it fits
  assign sk_sum  = SUM_W'(offset) + (SUM_W'(skip_count) << 3);

  assign cmd.go    = is_read && !rd_err && (bit_count != '0);
  assign cmd.err   = (is_read && rd_err) || (is_skip && sk_err);
  assign cmd.shift = offset[2:0];
  assign cmd.bits  = bit_count;
  assign base      = AW'(offset >> 3);

  assign wr_en   = accept && (req_type == REQ_LOAD) && (ICMP_W'(load_index) < IdxLim);
  assign wr_addr = AW'(load_index);
  assign wr_data = load_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_length <= '0;
      offset      <= '0;
    end else begin
      if (cfg_we) begin
        data_length <= cfg_data;
      end
      if (is_read && !rd_err) begin
        offset <= OFF_W'(rd_sum);
      end else if (is_skip && !sk_err) begin
        offset <= OFF_W'(sk_sum);
      end
    end
  end

endmodule

>>> sv/mbr_extract.sv
// Byte store and byte-serial extraction sequencer with the result register.
module mbr_extract import mbr_pkg::*; #(
  parameter int BUF_BYTES = DEF_BUF_BYTES,
  localparam int AW       = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  mbr_cmd_t          cmd,
  input  logic [AW-1:0]     base,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  output logic              busy,
  mbr_res_if.source         res
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_PRIME = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  logic [BYTE_W-1:0] mem [BUF_BYTES];

  state_t            state;
  logic              err_pend;
  logic [AW-1:0]     ptr;
  logic [2:0]        shift;
  logic [BCNT_W-1:0] remain;
  logic [BYTE_W-1:0] hi;
  logic [BYTE_W-1:0] rdata;
  logic              rd_en;
  logic              slot_free;
  logic              emit;
  logic [15:0]       win;
  logic [BYTE_W-1:0] win_byte;
  logic              tail;

  assign slot_free = !res.valid || res.ready;
  assign busy      = (state != ST_IDLE) || err_pend;
  // result register loads a data byte or the pending error result
  assign emit      = slot_free && ((state == ST_EMIT) || ((state == ST_IDLE) && err_pend));

  // memory reads advance only while the sequencer moves
  always_comb begin
    case (state)
      ST_FETCH: rd_en = 1'b1;
      ST_PRIME: rd_en = 1'b1;
      ST_EMIT:  rd_en = slot_free;
      default:  rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[ptr];
    end
  end

  // 16-bit window over two neighboring bytes, aligned to the bit offset
  assign win      = {hi, rdata} << shift;
  assign win_byte = win[15:8];
  assign tail     = remain < BCNT_W'(8);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      err_pend  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (emit) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (err_pend) begin
            if (slot_free) begin
              res.data_byte  <= '0;
              res.bits_valid <= '0;
              res.last       <= 1'b1;
              res.status     <= STATUS_EMPTY;
              err_pend       <= 1'b0;
            end
          end else if (cmd.err) begin
            err_pend <= 1'b1;
          end else if (cmd.go) begin
            ptr    <= base;
            shift  <= cmd.shift;
            remain <= cmd.bits;
            state  <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          ptr   <= ptr + AW'(1);
          state <= ST_PRIME;
        end
        ST_PRIME: begin
          hi    <= rdata;
          ptr   <= ptr + AW'(1);
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            res.status <= STATUS_OK;
            res.last   <= remain <= BCNT_W'(8);
            if (tail) begin
              res.data_byte  <= win_byte >> 3'(4'd8 - remain[3:0]);
              res.bits_valid <= remain[3:0];
            end else begin
              res.data_byte  <= win_byte;
              res.bits_valid <= BVAL_W'(8);
            end
            hi     <= rdata;
            ptr    <= ptr + AW'(1);
            remain <= remain - BCNT_W'(8);
            if (remain <= BCNT_W'(8)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sv/msb_first_bit_reader.sv
// Top level of the MSB-first bit reader over a byte buffer.
//
// Usage: requests arrive on req (valid/ready). A load request writes one buffer
// byte, a read request extracts bit_count bits MSB first from the current bit
// offset, a skip request moves the offset ahead by whole bytes. Results leave on
// res (valid/ready), one byte per result, last set on the final one; a partial
// final byte is right-aligned. A read or skip past the buffer length, or a read
// over MAX_READ_BITS, gives one result with status set and keeps the offset.
// data_length is written through cfg_we/cfg_data; the user must do so only while
// no request is in flight, as the block does not enforce it. Load, skip and
// passing zero-length reads complete when accepted. A read steps through the
// FETCH and PRIME states, which prime the byte store read port and its registered
// data, then moves one byte per cycle into the result register while the receiver
// does not stall. An error request sets a pending flag that then loads the error
// result. Reset clears the offset, the length and the sequencer; buffer contents
// stay undefined until loaded. A stalled receiver holds the result register and
// the sequencer in its emit state; req.ready stays low while a read is being
// extracted or an error result waits, and requests are taken once neither holds.
module msb_first_bit_reader import mbr_pkg::*; #(
  parameter int BUF_BYTES     = DEF_BUF_BYTES,
  parameter int MAX_READ_BITS = DEF_MAX_READ_BITS
) (
  input  logic             clk,
  input  logic             rst,
  mbr_req_if.sink          req,
  mbr_res_if.source        res,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data
);

  localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;

  logic              accept;
  logic              busy;
  mbr_cmd_t          cmd;
  logic [AW-1:0]     base;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;

  // requests are taken whenever the extraction sequencer is idle and no error result waits
  assign req.ready = !busy;
  assign accept    = req.valid && req.ready;

  mbr_ctrl #(
    .BUF_BYTES     (BUF_BYTES),
    .MAX_READ_BITS (MAX_READ_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req_type   (req.req_type),
    .load_index (req.load_index),
    .load_byte  (req.load_byte),
    .bit_count  (req.bit_count),
    .skip_count (req.skip_count),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .base       (base),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  mbr_extract #(
    .BUF_BYTES (BUF_BYTES)
  ) u_extract (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .base    (base),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .busy    (busy),
    .res     (res)
  );

endmodule
